@@ rtl/segment_fit_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL
`ifndef SEGMENT_FIT_ALLOCATOR_ASSERT_SVH
`define SEGMENT_FIT_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define SFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/sfa_pkg.sv @@
//------------------------------------------------------------------------------
// sfa_pkg
// Types, constants and codes for the segment fit allocator.
//------------------------------------------------------------------------------
package sfa_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int SEG_SLOTS  = 64;
    localparam int ADDR_BITS  = 20;
    localparam int FIDX_BITS  = $clog2(FREE_SLOTS);
    localparam int SIDX_BITS  = $clog2(SEG_SLOTS);
    localparam int LEN_BITS   = ADDR_BITS + 1;
    localparam int CFG_BITS   = 21;
    localparam int SIZE_BITS  = 21;

    localparam logic [0:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [0:0] CFG_MEMORY_SIZE = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_TOTAL = 3'd1;
    localparam logic [2:0] ST_NO_FIT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [15:0] program_id;
        logic [20:0] segment_size;
        logic [31:0] logical_start;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  status;
        logic [19:0] base_address;
        logic [20:0] free_total;
    } rsp_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_FSCAN,
        S_SSCAN,
        S_ALLOC_WR,
        S_RSCAN,
        S_RDECIDE,
        S_RWALK,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic init;       // clear tables
        logic load;       // capture request, reset scan
        logic fstep;      // free-table scan step (pick, count, sum)
        logic sstep;      // segment scan step
        logic commit;     // write allocation
        logic rwalk;      // release walk step
        logic rsp_load;   // latch result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fdone;
        logic sdone;
        logic rdone;
        logic is_release;
        logic alloc_ok;
        logic rel_ok;
    } sts_t;

endpackage

@@ rtl/sfa_if.sv @@
//------------------------------------------------------------------------------
// sfa_stream_if
// Valid/ready channel carrying one payload.
//------------------------------------------------------------------------------
interface sfa_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sfa_ctrl.sv @@
//------------------------------------------------------------------------------
// sfa_ctrl
// Sequencer for table scans, allocation commit and release walk.
//------------------------------------------------------------------------------
module sfa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_init,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  sfa_pkg::sts_t   sts,
    output sfa_pkg::cmd_t   cmd
);
    import sfa_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_init)
            state_next = S_INIT;
        else
        begin
            case (state_reg)
                S_INIT:     state_next = S_IDLE;
                S_IDLE:     if (in_valid) state_next = S_FSCAN;
                S_FSCAN:    if (sts.fdone) state_next = S_SSCAN;
                S_SSCAN:
                    if (sts.sdone)
                        state_next = sts.is_release ? S_RDECIDE
                                   : (sts.alloc_ok ? S_ALLOC_WR : S_RESP);
                S_ALLOC_WR: state_next = S_RESP;
                S_RDECIDE:  state_next = sts.rel_ok ? S_RWALK : S_RESP;
                S_RWALK:    if (sts.rdone) state_next = S_RESP;
                S_RESP:     if (!ov_reg || out_ready) state_next = S_IDLE;
                default:    state_next = S_INIT;
            endcase
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE) && !cfg_init;
        cmd.init   = (state_reg == S_INIT);
        cmd.load   = in_ready && in_valid;
        cmd.fstep  = (state_reg == S_FSCAN);
        cmd.sstep  = (state_reg == S_SSCAN);
        cmd.commit = (state_reg == S_ALLOC_WR);
        cmd.rwalk  = (state_reg == S_RWALK);
        cmd.rsp_load = (state_reg == S_RESP) && (!ov_reg || out_ready);
        ov_next    = cmd.rsp_load ? 1'b1 : ((out_ready) ? 1'b0 : ov_reg);
        out_valid  = ov_reg;
    end

endmodule

@@ rtl/sfa_datapath.sv @@
//------------------------------------------------------------------------------
// sfa_datapath
// Free and segment tables, scan registers and result register.
//------------------------------------------------------------------------------
module sfa_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fit_mode,
    input  logic [sfa_pkg::LEN_BITS-1:0] mem_size,
    input  sfa_pkg::req_t  req,
    input  sfa_pkg::cmd_t  cmd,
    output sfa_pkg::sts_t  sts,
    output sfa_pkg::rsp_t  rsp
);
    import sfa_pkg::*;

    logic [ADDR_BITS-1:0] fstart_mem [FREE_SLOTS];
    logic [LEN_BITS-1:0]  flen_mem   [FREE_SLOTS];
    logic [FREE_SLOTS-1:0] fvalid_reg;
    logic [15:0]          sown_mem   [SEG_SLOTS];
    logic [31:0]          slog_mem   [SEG_SLOTS];
    logic [ADDR_BITS-1:0] sbase_mem  [SEG_SLOTS];
    logic [LEN_BITS-1:0]  slen_mem   [SEG_SLOTS];
    logic [SEG_SLOTS-1:0] svalid_reg;

    req_t                 req_reg;
    logic [FIDX_BITS:0]   fi_reg;
    logic [SIDX_BITS:0]   si_reg;
    logic [LEN_BITS-1:0]  total_reg;
    logic                 pick_ok_reg, slot_ok_reg, found_reg;
    logic [FIDX_BITS-1:0] pick_reg;
    logic [ADDR_BITS-1:0] pstart_reg;
    logic [LEN_BITS-1:0]  plen_reg;
    logic [SIDX_BITS-1:0] slot_reg;
    logic [FIDX_BITS:0]   empty_reg, need_reg;
    logic [FIDX_BITS:0]   fw_reg;
    rsp_t                 rsp_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic                 acc_reg;
    logic [ADDR_BITS-1:0] fstart_rd_reg;
    logic [LEN_BITS-1:0]  flen_rd_reg;
    logic [15:0]          sown_rd_reg;
    logic [ADDR_BITS-1:0] sbase_rd_reg;
    logic [LEN_BITS-1:0]  slen_rd_reg;

    logic [FIDX_BITS-1:0] fi;
    logic [SIDX_BITS-1:0] si;
    logic [FIDX_BITS-1:0] fw;
    logic [FIDX_BITS:0]   fi_next;
    logic [SIDX_BITS:0]   si_next;
    logic [LEN_BITS-1:0]  size_c;
    logic                 fits, better, own;
    logic                 seg_live, place, skip;
    logic [ADDR_BITS-1:0] cstart;
    logic [LEN_BITS-1:0]  clen;
    logic [LEN_BITS-1:0]  msz;
    logic [2:0]           status_c;

    assign fi     = fi_reg[FIDX_BITS-1:0];
    assign si     = si_reg[SIDX_BITS-1:0];
    assign fw     = fw_reg[FIDX_BITS-1:0];
    assign size_c = req_reg.segment_size;
    assign cstart = fstart_rd_reg;
    assign clen   = flen_rd_reg;
    assign fits   = fvalid_reg[fi] && (clen >= size_c);
    assign better = !pick_ok_reg ||
                    (!fit_mode && cstart < pstart_reg) ||
                    (fit_mode && (clen > plen_reg ||
                                  (clen == plen_reg && cstart < pstart_reg)));
    assign own    = svalid_reg[si] && (sown_rd_reg == req_reg.program_id);
    assign msz    = (mem_size > LEN_BITS'(1 << ADDR_BITS))
                    ? LEN_BITS'(1 << ADDR_BITS) : mem_size;

    // release walk: place a segment into an empty free entry, or skip an occupied one
    assign seg_live = (slen_rd_reg != '0);
    assign place    = cmd.rwalk && !si_reg[SIDX_BITS] && own && seg_live && !fvalid_reg[fw];
    assign skip     = cmd.rwalk && !si_reg[SIDX_BITS] && own && seg_live && fvalid_reg[fw];

    // scan indexes for the next cycle, also used as table read addresses
    always_comb
    begin
        fi_next = fi_reg;
        si_next = si_reg;
        if (cmd.load)
        begin
            fi_next = '0;
            si_next = '0;
        end
        else if (cmd.fstep)
            fi_next = fi_reg + 1'b1;
        else if (cmd.sstep)
        begin
            if (sts.sdone && req_reg.opcode == OP_RELEASE)
                si_next = '0;
            else
                si_next = si_reg + 1'b1;
        end
        else if (cmd.rwalk && !si_reg[SIDX_BITS] && !skip)
            si_next = si_reg + 1'b1;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg <= FREE_SLOTS'(1);
            svalid_reg <= '0;
        end
        else if (cmd.init)
        begin
            fvalid_reg <= (msz != '0) ? FREE_SLOTS'(1) : '0;
            svalid_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (plen_reg == size_c) fvalid_reg[pick_reg] <= 1'b0;
            svalid_reg[slot_reg] <= 1'b1;
        end
        else if (cmd.rwalk && !si_reg[SIDX_BITS] && own && !skip)
        begin
            svalid_reg[si] <= 1'b0;
            if (place) fvalid_reg[fw] <= 1'b1;
        end
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (cmd.init || !rst_n)
        begin
            fstart_mem[0] <= '0;
            flen_mem[0]   <= (!rst_n) ? LEN_BITS'(1 << ADDR_BITS) : msz;
        end
        else if (cmd.commit)
        begin
            fstart_mem[pick_reg] <= pstart_reg + ADDR_BITS'(size_c);
            flen_mem[pick_reg]   <= plen_reg - size_c;
            sown_mem[slot_reg]   <= req_reg.program_id;
            slog_mem[slot_reg]   <= req_reg.logical_start;
            sbase_mem[slot_reg]  <= pstart_reg;
            slen_mem[slot_reg]   <= size_c;
        end
        else if (place)
        begin
            fstart_mem[fw] <= sbase_rd_reg;
            flen_mem[fw]   <= slen_rd_reg;
        end
    end

    // registered table reads, one entry ahead of the scan
    always_ff @(posedge clk)
    begin
        fstart_rd_reg <= fstart_mem[fi_next[FIDX_BITS-1:0]];
        flen_rd_reg   <= flen_mem[fi_next[FIDX_BITS-1:0]];
        sown_rd_reg   <= sown_mem[si_next[SIDX_BITS-1:0]];
        sbase_rd_reg  <= sbase_mem[si_next[SIDX_BITS-1:0]];
        slen_rd_reg   <= slen_mem[si_next[SIDX_BITS-1:0]];
    end

    // scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req;
            fi_reg      <= '0;
            si_reg      <= '0;
            total_reg   <= '0;
            pick_ok_reg <= 1'b0;
            slot_ok_reg <= 1'b0;
            found_reg   <= 1'b0;
            empty_reg   <= '0;
            need_reg    <= '0;
            fw_reg      <= '0;
            acc_reg     <= 1'b0;
            base_reg    <= '0;
        end
        else if (cmd.fstep)
        begin
            fi_reg <= fi_next;
            if (fvalid_reg[fi])
                total_reg <= total_reg + clen;
            else
                empty_reg <= empty_reg + 1'b1;
            if (fits && better)
            begin
                pick_ok_reg <= 1'b1;
                pick_reg    <= fi;
                pstart_reg  <= cstart;
                plen_reg    <= clen;
            end
        end
        else if (cmd.sstep)
        begin
            si_reg <= si_next;
            if (!svalid_reg[si] && !slot_ok_reg)
            begin
                slot_ok_reg <= 1'b1;
                slot_reg    <= si;
            end
            if (own)
            begin
                found_reg <= 1'b1;
                if (seg_live) need_reg <= need_reg + 1'b1;
            end
        end
        else if (cmd.commit)
        begin
            acc_reg   <= 1'b1;
            base_reg  <= pstart_reg;
            total_reg <= total_reg - size_c;
        end
        else if (cmd.rwalk)
        begin
            acc_reg <= 1'b1;
            si_reg  <= si_next;
            if (place)
            begin
                total_reg <= total_reg + slen_rd_reg;
                fw_reg    <= fw_reg + 1'b1;
            end
            else if (skip)
                fw_reg <= fw_reg + 1'b1;
        end
    end

    // refusal code in check order
    always_comb
    begin
        status_c = ST_OK;
        if (req_reg.opcode == OP_ALLOC)
        begin
            if (size_c > total_reg && !acc_reg) status_c = ST_NO_TOTAL;
            else if (!pick_ok_reg)              status_c = ST_NO_FIT;
            else if (!slot_ok_reg)              status_c = ST_FULL;
        end
        else
        begin
            if (!found_reg)                     status_c = ST_UNKNOWN;
            else if (need_reg > empty_reg)      status_c = ST_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_reg.accepted     <= acc_reg;
            rsp_reg.status       <= acc_reg ? ST_OK : status_c;
            rsp_reg.base_address <= acc_reg ? base_reg : '0;
            rsp_reg.free_total   <= total_reg;
        end
    end

    assign rsp            = rsp_reg;
    assign sts.fdone      = (fi_reg == (FIDX_BITS+1)'(FREE_SLOTS - 1));
    assign sts.sdone      = (si_reg == (SIDX_BITS+1)'(SEG_SLOTS - 1));
    assign sts.rdone      = si_reg[SIDX_BITS];
    assign sts.is_release = (req_reg.opcode == OP_RELEASE);
    assign sts.alloc_ok   = !(size_c > total_reg) && pick_ok_reg &&
                            (slot_ok_reg || !svalid_reg[si]);
    assign sts.rel_ok     = found_reg && !(need_reg > empty_reg);

endmodule

@@ rtl/segment_fit_allocator.sv @@
//------------------------------------------------------------------------------
// segment_fit_allocator
// First-fit / worst-fit segment allocator with a free table and segment table.
//------------------------------------------------------------------------------
// Channel   Dir  Payload
// req       in   opcode, program_id, segment_size, logical_start
// rsp       out  accepted, status, base_address, free_total
// cfg       in   wr_en, wr_index, wr_data
//
// An allocate scans one free-table entry then one segment entry per cycle.
// A release runs both scans, then a walk that steps one segment or skips
// one occupied free entry per cycle.
// After reset or a memory_size write, the S_INIT state rebuilds the tables.
// A held result stalls the next one in its final cycle; one request may be
// accepted and processed while a result waits.
module segment_fit_allocator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic [0:0] wr_index,
    input  logic [sfa_pkg::CFG_BITS-1:0] wr_data,
    sfa_stream_if.sink   req,
    sfa_stream_if.source rsp
);
    import sfa_pkg::*;
    `include "segment_fit_allocator_assert.svh"

    logic                fit_mode_reg;
    logic [LEN_BITS-1:0] mem_size_reg;
    logic                cfg_init;
    cmd_t                cmd;
    sts_t                sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= 1'b0;
            mem_size_reg <= LEN_BITS'(1 << ADDR_BITS);
        end
        else if (wr_en)
        begin
            if (wr_index == CFG_FIT_MODE)
                fit_mode_reg <= wr_data[0];
            else
                mem_size_reg <= wr_data[LEN_BITS-1:0];
        end
    end

    assign cfg_init = wr_en && (wr_index == CFG_MEMORY_SIZE);

    sfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_init  (cfg_init),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sfa_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .fit_mode (fit_mode_reg),
        .mem_size (mem_size_reg),
        .req      (req.payload),
        .cmd      (cmd),
        .sts      (sts),
        .rsp      (rsp.payload)
    );

    `SFA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, cmd.fstep, !req.ready)
    `SFA_ASSERT_NEXT(a_load_scans, clk, rst_n, cmd.load && !cfg_init, cmd.fstep)
    `SFA_ASSERT_IMP(a_ok_status, clk, rst_n, rsp.valid && rsp.payload.accepted,
                    rsp.payload.status == ST_OK)

endmodule
